>>> hdl/vwma_pkg.sv
// Shared types and constants of the vector weighted moving average block.
// Register index codes, field widths and the fixed-point format live here.
// No dependencies.
package vwma_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int CHAN_OUT_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int WEIGHT_W    = 16;
    localparam int NUM_WEIGHTS = 6;
    localparam int PROD_W      = 48;
    localparam int FRAC_SHIFT  = 15;
    localparam int ROUND_BIAS  = 16384;
    localparam int OUT_TDATA_W = 40;

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [WEIGHT_W-1:0]   weight_t;
    typedef logic [3:0]            chan_count_t;
    typedef logic [2:0]            win_len_t;

    localparam cfg_index_t REG_CHANNEL_COUNT = 3'd0;
    localparam cfg_index_t REG_WINDOW_LEN    = 3'd1;
    localparam cfg_index_t REG_TAP_WEIGHT_0  = 3'd2;

    localparam chan_count_t RST_CHANNEL_COUNT = 4'd8;
    localparam win_len_t    RST_WINDOW_LEN    = 3'd1;
    localparam weight_t     RST_WEIGHT_FIRST  = 16'h8000;
    localparam weight_t     RST_WEIGHT_OTHER  = 16'h0000;

endpackage

>>> hdl/vector_weighted_moving_average.sv
// Weighted moving average over a window of stored vectors, one element per item.
// Holds the history ring memory, the pending vector, the sequencer and the
// shared multiply-accumulate unit. Depends on vwma_pkg.

// Elements stream in at one item per cycle while the block is idle. After the
// closing element the block stops taking items and works the vector with one
// shared multiplier: a duplicate check against the newest stored vector (only
// once the ring holds a vector; an exact repeat ends there with no result), a
// step to advance the newest slot, a copy of all MAX_CHANNELS pending entries
// into the ring, then per channel either a pass-through of the value (window
// not yet full) or a read of each tap from the ring's one read port, multiply,
// add, round and saturate. The one ring read port and the one multiplier make
// the channels go one after another, and a stalled result output holds the
// sequencer.
// A length mismatch gives a single error result, with no check or ring update.
// Results leave through an output register, so the next vector may start
// while the last result still waits. The ring needs no clearing after reset.
module vector_weighted_moving_average #(
    parameter int MAX_TAPS     = 6,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wen,
    input  vwma_pkg::cfg_index_t  cfg_index,
    input  vwma_pkg::cfg_data_t   cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] sample
    input  logic                  s_tlast,   // end_of_vector
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [31:0] filtered_value, [34:32] channel_index
    output logic                  m_tuser,   // status
    output logic                  m_tlast    // last_result
);
    import vwma_pkg::*;

    localparam int DEPTH  = MAX_TAPS * MAX_CHANNELS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EC_W   = $clog2(MAX_CHANNELS + 2);
    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TAP_W  = $clog2(MAX_TAPS + 1);
    localparam int SLOT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_TAPS + 1);
    localparam int RND_W  = ACC_W - FRAC_SHIFT;
    localparam int PAD_W  = OUT_TDATA_W - SAMPLE_W - CHAN_OUT_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ERR  = 4'd1;
    localparam logic [3:0] ST_CMP  = 4'd2;
    localparam logic [3:0] ST_ADV  = 4'd3;
    localparam logic [3:0] ST_COPY = 4'd4;
    localparam logic [3:0] ST_PASS = 4'd5;
    localparam logic [3:0] ST_MAC  = 4'd6;
    localparam logic [3:0] ST_MDRN = 4'd7;
    localparam logic [3:0] ST_EMIT = 4'd8;

    // configuration
    chan_count_t chan_cnt_reg;
    win_len_t    win_len_reg;
    weight_t     weight_reg [NUM_WEIGHTS];

    // storage
    sample_t     ring_mem [DEPTH];
    sample_t     pend_reg [MAX_CHANNELS];

    // sequencer
    logic [3:0]        state_reg, state_next;
    logic [EC_W-1:0]   elem_cnt_reg, elem_cnt_next;
    logic [TAP_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0] newest_reg, newest_next;
    logic              full_reg, full_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] start_slot_reg, start_slot_next;
    logic              diff_reg, diff_next;

    // shared multiply-accumulate pipeline
    logic                    s1_vld_reg, s2_vld_reg;
    logic [CH_W-1:0]         chk_idx_reg;
    weight_t                 wt_s1_reg;
    sample_t                 rd_data_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // output register
    logic                   out_valid_reg;
    sample_t                out_value_reg;
    logic [CHAN_OUT_W-1:0]  out_chan_reg;
    logic                   out_err_reg;
    logic                   out_last_reg;

    // combinational controls
    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    sample_t                out_value;
    logic [CHAN_OUT_W-1:0]  out_chan;
    logic                   out_err;
    logic                   out_last;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic                   acc_clr;
    logic [IDX_W-1:0]       pend_idx;
    sample_t                pend_rd;
    weight_t                wt_sel;
    logic [TAP_W-1:0]       w_eff;
    logic [EC_W-1:0]        ec_inc;
    logic                   len_bad;
    logic                   ch_last;
    logic                   chk_last;
    logic                   mismatch;
    logic [SLOT_W:0]        start_sum;
    logic [SLOT_W-1:0]      start_slot;
    logic [SLOT_W-1:0]      slot_inc;
    logic [SLOT_W-1:0]      newest_inc;
    logic signed [ACC_W-1:0] acc_biased;
    logic signed [RND_W-1:0] rnd;
    sample_t                sat_value;

    function automatic logic [AW-1:0] ring_addr(input logic [SLOT_W-1:0] slot,
                                                input logic [CH_W-1:0] ch);
        return AW'(32'(slot) * MAX_CHANNELS + 32'(ch));
    endfunction

    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] nxt;
        nxt = (32'(slot) == MAX_TAPS - 1) ? '0 : slot + SLOT_W'(1);
        return nxt;
    endfunction

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cnt_reg <= RST_CHANNEL_COUNT;
            win_len_reg  <= RST_WINDOW_LEN;
            for (int k = 0; k < NUM_WEIGHTS; k++) begin
                weight_reg[k] <= (k == 0) ? RST_WEIGHT_FIRST : RST_WEIGHT_OTHER;
            end
        end else if (cfg_wen) begin
            if (cfg_index == REG_CHANNEL_COUNT) begin
                chan_cnt_reg <= cfg_wdata[3:0];
            end
            if (cfg_index == REG_WINDOW_LEN) begin
                win_len_reg <= cfg_wdata[2:0];
            end
            for (int k = 0; k < NUM_WEIGHTS; k++) begin
                if (32'(cfg_index) == 32'(REG_TAP_WEIGHT_0) + k) begin
                    weight_reg[k] <= cfg_wdata;
                end
            end
        end
    end

    // ------------------------------------------------------- derived values
    always_comb begin
        if (win_len_reg == '0) begin
            w_eff = TAP_W'(1);
        end else if (32'(win_len_reg) > MAX_TAPS) begin
            w_eff = TAP_W'(MAX_TAPS);
        end else begin
            w_eff = TAP_W'(win_len_reg);
        end
    end

    always_comb begin
        wt_sel = '0;
        for (int k = 0; k < NUM_WEIGHTS; k++) begin
            if (32'(tap_reg) == k) begin
                wt_sel = weight_reg[k];
            end
        end
    end

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign ec_inc  = (32'(elem_cnt_reg) <= MAX_CHANNELS) ? elem_cnt_reg + EC_W'(1)
                                                         : elem_cnt_reg;
    assign len_bad = (chan_cnt_reg == '0) || (32'(chan_cnt_reg) > MAX_CHANNELS)
                     || (32'(ec_inc) != 32'(chan_cnt_reg));
    assign ch_last  = (32'(ch_reg) + 1 == 32'(chan_cnt_reg));
    assign chk_last = (32'(chk_idx_reg) + 1 == 32'(chan_cnt_reg));

    assign pend_idx = (state_reg == ST_CMP) ? chk_idx_reg[IDX_W-1:0] : ch_reg[IDX_W-1:0];
    assign pend_rd  = pend_reg[pend_idx];
    assign mismatch = (rd_data_reg != pend_rd);

    // first tap of the window: newest - (w - 1), modulo MAX_TAPS
    assign start_sum  = {1'b0, newest_reg} + (SLOT_W+1)'(MAX_TAPS)
                        - (SLOT_W+1)'(w_eff - TAP_W'(1));
    assign start_slot = (32'(start_sum) >= MAX_TAPS) ? SLOT_W'(32'(start_sum) - MAX_TAPS)
                                                     : start_sum[SLOT_W-1:0];
    assign slot_inc   = slot_wrap(slot_reg);
    assign newest_inc = slot_wrap(newest_reg);

    // round half up at bit 15, then saturate to 32 bits
    assign acc_biased = acc_reg + ACC_W'(ROUND_BIAS);
    assign rnd        = acc_biased[ACC_W-1:FRAC_SHIFT];
    always_comb begin
        if ((&rnd[RND_W-1:SAMPLE_W-1]) || !(|rnd[RND_W-1:SAMPLE_W-1])) begin
            sat_value = rnd[SAMPLE_W-1:0];
        end else if (rnd[RND_W-1]) begin
            sat_value = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------ sequencer
    always_comb begin
        state_next      = state_reg;
        elem_cnt_next   = elem_cnt_reg;
        fill_next       = fill_reg;
        newest_next     = newest_reg;
        full_next       = full_reg;
        ch_next         = ch_reg;
        tap_next        = tap_reg;
        slot_next       = slot_reg;
        start_slot_next = start_slot_reg;
        diff_next       = diff_reg;
        rd_en           = 1'b0;
        rd_addr         = ring_addr(newest_reg, ch_reg);
        wr_en           = 1'b0;
        wr_addr         = ring_addr(newest_reg, ch_reg);
        acc_clr         = 1'b0;
        out_load        = 1'b0;
        out_value       = '0;
        out_chan        = CHAN_OUT_W'(ch_reg);
        out_err         = 1'b0;
        out_last        = ch_last;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    elem_cnt_next = ec_inc;
                    if (s_tlast) begin
                        elem_cnt_next = '0;
                        ch_next       = '0;
                        diff_next     = 1'b0;
                        if (len_bad) begin
                            state_next = ST_ERR;
                        end else if (fill_reg != '0) begin
                            state_next = ST_CMP;
                        end else begin
                            state_next = ST_ADV;
                        end
                    end
                end
            end
            ST_ERR: begin
                out_chan = '0;
                out_err  = 1'b1;
                out_last = 1'b1;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CMP: begin
                // issue reads of the newest vector, check each in the next cycle
                if (32'(ch_reg) < 32'(chan_cnt_reg)) begin
                    rd_en   = 1'b1;
                    ch_next = ch_reg + CH_W'(1);
                end
                if (s1_vld_reg) begin
                    diff_next = diff_reg || mismatch;
                    if (chk_last) begin
                        state_next = (diff_reg || mismatch) ? ST_ADV : ST_IDLE;
                    end
                end
            end
            ST_ADV: begin
                newest_next = (fill_reg == '0) ? newest_reg : newest_inc;
                if (fill_reg >= w_eff) begin
                    fill_next = w_eff;
                    full_next = 1'b1;
                end else begin
                    fill_next = fill_reg + TAP_W'(1);
                    full_next = (fill_reg + TAP_W'(1) >= w_eff);
                end
                ch_next    = '0;
                state_next = ST_COPY;
            end
            ST_COPY: begin
                wr_en   = 1'b1;
                ch_next = ch_reg + CH_W'(1);
                if (32'(ch_reg) == MAX_CHANNELS - 1) begin
                    ch_next         = '0;
                    tap_next        = '0;
                    slot_next       = start_slot;
                    start_slot_next = start_slot;
                    acc_clr         = 1'b1;
                    state_next      = full_reg ? ST_MAC : ST_PASS;
                end
            end
            ST_PASS: begin
                out_value = pend_rd;
                if (out_free) begin
                    out_load = 1'b1;
                    ch_next  = ch_reg + CH_W'(1);
                    if (ch_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MAC: begin
                rd_en     = 1'b1;
                rd_addr   = ring_addr(slot_reg, ch_reg);
                tap_next  = tap_reg + TAP_W'(1);
                slot_next = slot_inc;
                if (tap_reg == w_eff - TAP_W'(1)) begin
                    state_next = ST_MDRN;
                end
            end
            ST_MDRN: begin
                if (!s1_vld_reg && !s2_vld_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                out_value = sat_value;
                if (out_free) begin
                    out_load = 1'b1;
                    if (ch_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ch_next    = ch_reg + CH_W'(1);
                        tap_next   = '0;
                        slot_next  = start_slot_reg;
                        acc_clr    = 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            elem_cnt_reg   <= '0;
            fill_reg       <= '0;
            newest_reg     <= '0;
            full_reg       <= 1'b0;
            ch_reg         <= '0;
            tap_reg        <= '0;
            slot_reg       <= '0;
            start_slot_reg <= '0;
            diff_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            elem_cnt_reg   <= elem_cnt_next;
            fill_reg       <= fill_next;
            newest_reg     <= newest_next;
            full_reg       <= full_next;
            ch_reg         <= ch_next;
            tap_reg        <= tap_next;
            slot_reg       <= slot_next;
            start_slot_reg <= start_slot_next;
            diff_reg       <= diff_next;
        end
    end

    // -------------------------------------------------------------- storage
    always_ff @(posedge aclk) begin
        if (accept && (32'(elem_cnt_reg) < MAX_CHANNELS)) begin
            pend_reg[elem_cnt_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= pend_rd;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // ----------------------------------------------- shared multiply-add unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= rd_en;
            s2_vld_reg <= s1_vld_reg && ((state_reg == ST_MAC) || (state_reg == ST_MDRN));
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg <= ch_reg;
        wt_s1_reg   <= wt_sel;
        prod_reg    <= PROD_W'($signed(rd_data_reg) * $signed({1'b0, wt_s1_reg}));
        if (acc_clr) begin
            acc_reg <= '0;
        end else if (s2_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= out_value;
            out_chan_reg  <= out_chan;
            out_err_reg   <= out_err;
            out_last_reg  <= out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_chan_reg, out_value_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------ assertions
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_valid_reg) |-> m_tready)
        else $error("result register loaded while an item still waits");

    a_emit_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (!s1_vld_reg && !s2_vld_reg))
        else $error("accumulator read before the multiply pipeline drained");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[34:0] == 35'd0)))
        else $error("error result is not a single zero item");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(fill_reg) <= MAX_TAPS) && (32'(newest_reg) < MAX_TAPS))
        else $error("ring fill or slot pointer out of range");

endmodule

>>> sim/tb_vector_weighted_moving_average.sv
// Testbench for vector_weighted_moving_average: random vectors, repeats and
// bad lengths across several window and weight settings, checked per result.
// Depends on vwma_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_vector_weighted_moving_average;
    import vwma_pkg::*;

    localparam int MAX_TAPS        = 6;
    localparam int MAX_CHANNELS    = 8;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 150;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int MAX_LEN         = 12;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        sample_t               value;
        logic [CHAN_OUT_W-1:0] channel;
        logic                  status;
        logic                  last;
    } result_t;

    class wma_scoreboard;
        chan_count_t chan_count;
        win_len_t    window_len;
        weight_t     weight[NUM_WEIGHTS];
        sample_t     history[MAX_TAPS][MAX_CHANNELS];
        sample_t     pending[MAX_CHANNELS];
        int unsigned fill, newest, elem_count;
        result_t     expected_results[$];
        int unsigned elements, stored, duplicates, length_errors, checked, mismatches;

        function new();
            chan_count = RST_CHANNEL_COUNT;
            window_len = RST_WINDOW_LEN;
            weight[0] = RST_WEIGHT_FIRST;
            for (int i = 1; i < NUM_WEIGHTS; i++) weight[i] = RST_WEIGHT_OTHER;
            fill = 0;
            newest = 0;
            elem_count = 0;
            elements = 0;
            stored = 0;
            duplicates = 0;
            length_errors = 0;
            checked = 0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, cfg_data_t data);
            if (idx == REG_CHANNEL_COUNT) chan_count = data[3:0];
            else if (idx == REG_WINDOW_LEN) window_len = data[2:0];
            else weight[idx - REG_TAP_WEIGHT_0] = data;
        endfunction

        // round half up from Q17.31 to Q16.16, then clamp to 32 bits
        function sample_t round_saturate(longint acc);
            longint q;
            q = (acc + ROUND_BIAS) >>> FRAC_SHIFT;
            if (q > 64'sd2147483647) return 32'h7FFF_FFFF;
            if (q < -64'sd2147483648) return 32'h8000_0000;
            return q[31:0];
        endfunction

        function void push_result(sample_t v, int unsigned ch, bit st, bit last);
            result_t r;
            r.value = v;
            r.channel = ch[CHAN_OUT_W-1:0];
            r.status = st;
            r.last = last;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void note_element(sample_t smp, bit eov);
            int unsigned len, win, slot;
            bit          same, full;
            longint      acc;
            sample_t     v;
            elements++;
            if (elem_count < MAX_CHANNELS) pending[elem_count] = smp;
            if (elem_count <= MAX_CHANNELS) elem_count++;
            if (!eov) return;
            len = elem_count;
            elem_count = 0;
            if (chan_count == 0 || chan_count > MAX_CHANNELS || len != chan_count) begin
                length_errors++;
                push_result('0, 0, 1'b1, 1'b1);
                return;
            end
            // drop a vector identical to the newest one in the ring
            if (fill > 0) begin
                same = 1'b1;
                for (int c = 0; c < chan_count; c++)
                    if (history[newest][c] != pending[c]) same = 1'b0;
                if (same) begin
                    duplicates++;
                    return;
                end
            end
            win = (window_len == 0) ? 1 : (window_len > MAX_TAPS) ? MAX_TAPS : window_len;
            if (fill != 0) newest = (newest + 1) % MAX_TAPS;
            history[newest] = pending;
            fill = (fill >= win) ? win : fill + 1;
            full = (fill >= win);
            stored++;
            for (int c = 0; c < chan_count; c++) begin
                if (!full) begin
                    v = pending[c];
                end else begin
                    acc = 0;
                    for (int j = 0; j < win; j++) begin
                        slot = (newest + MAX_TAPS - (win - 1) + j) % MAX_TAPS;
                        acc += longint'($signed(history[slot][c])) * longint'(weight[j]);
                    end
                    v = round_saturate(acc);
                end
                push_result(v, c, 1'b0, c + 1 == chan_count);
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic user, logic last);
            result_t want;
            checked++;
            if (expected_results.size() == 0) begin
                report($sformatf("result with none expected: value %h ch %0d status %b last %b",
                                 data[31:0], data[34:32], user, last));
                return;
            end
            want = expected_results.pop_front();
            if (data[31:0] !== want.value || data[34:32] !== want.channel ||
                user !== want.status || last !== want.last)
                report($sformatf({"expected value %h ch %0d status %b last %b, ",
                                  "got value %h ch %0d status %b last %b"},
                                 want.value, want.channel, want.status, want.last,
                                 data[31:0], data[34:32], user, last));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wen   = 1'b0;
    cfg_index_t             cfg_index = '0;
    cfg_data_t              cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    int unsigned   src_idle_pct = 0;
    int unsigned   snk_idle_pct = 0;
    wma_scoreboard sb;

    vector_weighted_moving_average #(
        .MAX_TAPS     (MAX_TAPS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return sample_t'($urandom_range(0, 131071)) - 32'd65536;
            default: return $urandom();
        endcase
    endfunction

    function automatic weight_t pick_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'h8000;
            2: return weight_t'($urandom());
            default: return weight_t'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_item(sample_t smp, bit eov);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= eov;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_element(smp, eov);
    endtask

    task automatic send_vector(sample_t vec[MAX_LEN], int len);
        for (int i = 0; i < len; i++) send_item(vec[i], i == len - 1);
    endtask

    // hold the input idle until every expected result is out, then let the
    // block finish any repeat check that produces nothing
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(chan_count_t n, win_len_t w, weight_t wts[NUM_WEIGHTS]);
        cfg_index_t idx;
        cfg_data_t  data;
        for (int r = 0; r < NUM_WEIGHTS + 2; r++) begin
            if (r == 0) begin
                idx  = REG_CHANNEL_COUNT;
                data = cfg_data_t'(n);
            end else if (r == 1) begin
                idx  = REG_WINDOW_LEN;
                data = cfg_data_t'(w);
            end else begin
                idx  = REG_TAP_WEIGHT_0 + cfg_index_t'(r - 2);
                data = wts[r - 2];
            end
            cfg_wen   <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= data;
            @(posedge aclk);
            sb.write_reg(idx, data);
        end
        cfg_wen <= 1'b0;
    endtask

    initial begin
        sample_t     vec[MAX_LEN];
        weight_t     wts[NUM_WEIGHTS];
        chan_count_t n;
        win_len_t    w;
        int          len, items, mode, ch;
        bit          in_range;

        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings pass each sample straight through. The first vector
        // is full length, so every ring entry read later has been written.
        vec[0] = 32'h7FFF_FFFF;
        vec[1] = 32'h8000_0000;
        vec[2] = 32'h0000_0000;
        vec[3] = 32'hFFFF_FFFF;
        vec[4] = 32'h0001_0000;
        vec[5] = 32'hFFFF_0000;
        vec[6] = 32'h0000_8000;
        vec[7] = pick_sample();
        send_vector(vec, 8);
        send_vector(vec, 8);          // exact repeat: no results
        vec[0] = pick_sample();
        send_vector(vec, 1);          // too short
        for (int i = 0; i < 10; i++) vec[i] = pick_sample();
        send_vector(vec, 10);         // too long, count saturates
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            src_idle_pct = (phase < 3) ? 22 : (phase < 6) ? 66 : 0;
            snk_idle_pct = (phase < 3) ? 66 : (phase < 6) ? 22 : 0;
            for (int j = 0; j < NUM_WEIGHTS; j++) wts[j] = pick_weight();
            case (phase)
                0: begin
                    n = 4'd8;
                    w = 3'd6;
                    for (int j = 0; j < NUM_WEIGHTS; j++) wts[j] = 16'h8000;
                end
                1: begin n = 4'd1; w = 3'd0; end
                2: begin n = 4'd3; w = 3'd7; end
                3: begin n = 4'd0; w = 3'd3; end
                4: begin
                    n = 4'd5;
                    w = 3'd4;
                    for (int j = 0; j < NUM_WEIGHTS; j++) wts[j] = weight_t'($urandom());
                end
                5: begin n = chan_count_t'($urandom_range(9, 15)); w = 3'd2; end
                6: begin n = 4'd8; w = 3'd1; end
                default: begin
                    n = chan_count_t'($urandom_range(1, MAX_CHANNELS));
                    w = win_len_t'($urandom_range(1, MAX_TAPS));
                end
            endcase
            apply_config(n, w, wts);
            in_range = (n >= 1 && n <= MAX_CHANNELS);

            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                mode = $urandom_range(0, 99);
                if (!in_range || mode < 12) begin
                    // wrong length, or any length when no length is valid
                    len = $urandom_range(1, 11);
                    if (in_range && len == n) len = n + 1;
                    for (int i = 0; i < len; i++) vec[i] = pick_sample();
                end else if (mode < 24 && sb.fill > 0) begin
                    // repeat the newest stored vector, sometimes with one bit off
                    len = n;
                    for (int i = 0; i < len; i++) vec[i] = sb.history[sb.newest][i];
                    if (mode >= 18) begin
                        ch = $urandom_range(0, len - 1);
                        vec[ch][$urandom_range(0, 31)] ^= 1'b1;
                    end
                end else begin
                    len = n;
                    for (int i = 0; i < len; i++) vec[i] = pick_sample();
                end
                send_vector(vec, len);
                items += len;
            end
            settle();
        end

        $display("Sent %0d items over %0d settings: %0d vectors filtered, %0d repeats,",
                 sb.elements, PHASES + 1, sb.stored, sb.duplicates);
        $display("%0d bad lengths.", sb.length_errors);
        $display("Checked %0d results with %0d mismatches and %0d still outstanding.",
                 sb.checked, sb.mismatches, sb.expected_results.size());
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/vwma_pkg.sv
hdl/vector_weighted_moving_average.sv
sim/tb_vector_weighted_moving_average.sv
